// ===== sv/priority_task_queue_scheduler_assert.svh =====
// assertion macros for the priority task queue scheduler
`ifndef PRIORITY_TASK_QUEUE_SCHEDULER_ASSERT_SVH
`define PRIORITY_TASK_QUEUE_SCHEDULER_ASSERT_SVH

`ifndef SYNTHESIS
`define PTQS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define PTQS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define PTQS_ASSERT(lbl, prop, msg)
`define PTQS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== sv/ptqs_pkg.sv =====
// types and codes shared by the priority task queue scheduler
package ptqs_pkg;

  typedef enum logic [1:0] {
    STAT_INSERTED = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_SCHED    = 2'd2,
    STAT_EMPTY    = 2'd3
  } status_e;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_RUN    = 1'b1;

  localparam int unsigned TIME_W = 20;

  typedef struct packed {
    logic [7:0] id;
    logic [3:0] prio;
    logic [9:0] burst;
  } entry_t;

  typedef struct packed {
    logic       action;
    logic [7:0] task_id;
    logic [3:0] priority_req;
    logic [9:0] burst;
  } item_t;

  typedef struct packed {
    status_e     status;
    logic [7:0]  out_task_id;
    logic [3:0]  out_priority;
    logic [9:0]  out_burst;
    logic [14:0] start_time;
    logic [14:0] finish_time;
    logic [19:0] turnaround_sum;
    logic [19:0] wait_sum;
    logic [5:0]  task_count;
    logic        last;
  } result_t;

  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctrl_t;

endpackage

// ===== sv/priority_task_queue_scheduler.sv =====
// priority task queue scheduler top level
//
// Command channel: an item on item_i is taken at a clock edge with start_i
// high and busy_o low. action insert places the task in a chain of slots
// kept sorted by descending priority, first in first out among equals; the
// status result (inserted, or full and dropped) appears on result_o with
// valid_o in the next cycle, and busy_o stays low, so inserts go one a cycle.
// action run drains the chain head first: busy_o is high while the queued
// tasks drain and one scheduled-task result leaves per cycle, each registered
// from a run-state cycle; the last carries the turnaround and wait sums
// and the task count, and the queue is then empty. A run on an empty queue
// gives one empty result in the next cycle.
// Throughput is set by the drain shift of the slot chain: one entry a cycle.
// Each result is on result_o for one cycle marked by valid_o; the receiver
// cannot stall it. Reset empties the queue and drops any run in progress.
`include "priority_task_queue_scheduler_assert.svh"

module priority_task_queue_scheduler #(
  parameter int unsigned QUEUE_DEPTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  ptqs_pkg::item_t   item_i,
  output logic              valid_o,
  output ptqs_pkg::result_t result_o
);

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

  state_e                      state_q, state_d;
  logic [CNT_W-1:0]            count_q, count_d;
  logic [CNT_W-1:0]            served_q, served_d;
  logic [ptqs_pkg::TIME_W-1:0] t_q, t_d;
  logic [ptqs_pkg::TIME_W-1:0] wsum_q, wsum_d;
  logic [ptqs_pkg::TIME_W-1:0] tsum_q, tsum_d;
  logic                        valid_q, valid_d;
  ptqs_pkg::result_t           result_q, result_d;

  logic                        accept;
  logic                        ins_xfer;
  logic                        ins_ack;
  logic                        full;
  logic [ptqs_pkg::TIME_W-1:0] finish;
  ptqs_pkg::cell_ctrl_t        ctrl;
  ptqs_pkg::entry_t            new_entry;
  ptqs_pkg::entry_t            entry_w [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]      keep_w;
  logic [QUEUE_DEPTH-1:0]      occupied;

  assign busy_o   = (state_q == ST_RUN);
  assign accept   = start_i && !busy_o;
  assign ins_xfer = accept && (item_i.action == ptqs_pkg::ACT_INSERT);
  assign ins_ack  = valid_o && ((result_o.status == ptqs_pkg::STAT_INSERTED) ||
                                (result_o.status == ptqs_pkg::STAT_FULL));
  assign full     = (count_q >= CNT_W'(QUEUE_DEPTH));
  assign valid_o  = valid_q;
  assign result_o = result_q;

  assign new_entry.id    = item_i.task_id;
  assign new_entry.prio  = item_i.priority_req;
  assign new_entry.burst = item_i.burst;

  assign ctrl.insert = ins_xfer && !full;
  assign ctrl.shift  = (state_q == ST_RUN);

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    ptqs_pkg::entry_t prev_entry;
    ptqs_pkg::entry_t next_entry;
    logic             prev_keep;

    assign occupied[i] = (CNT_W'(i) < count_q);

    if (i == 0) begin : g_head
      assign prev_keep  = 1'b1;
      assign prev_entry = '0;
    end else begin : g_body
      assign prev_keep  = keep_w[i-1];
      assign prev_entry = entry_w[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign next_entry = '0;
    end else begin : g_mid
      assign next_entry = entry_w[i+1];
    end

    ptqs_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .new_entry_i  (new_entry),
      .occupied_i   (occupied[i]),
      .prev_keep_i  (prev_keep),
      .prev_entry_i (prev_entry),
      .next_entry_i (next_entry),
      .keep_o       (keep_w[i]),
      .entry_o      (entry_w[i])
    );
  end

  assign finish = t_q + ptqs_pkg::TIME_W'(entry_w[0].burst);

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    served_d = served_q;
    t_d      = t_q;
    wsum_d   = wsum_q;
    tsum_d   = tsum_q;
    valid_d  = 1'b0;
    result_d = result_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          valid_d  = 1'b1;
          result_d = '0;
          if (item_i.action == ptqs_pkg::ACT_INSERT) begin
            if (full) begin
              result_d.status = ptqs_pkg::STAT_FULL;
            end else begin
              result_d.status = ptqs_pkg::STAT_INSERTED;
              count_d         = count_q + CNT_W'(1);
            end
          end else if (count_q == '0) begin
            result_d.status = ptqs_pkg::STAT_EMPTY;
            result_d.last   = 1'b1;
          end else begin
            valid_d  = 1'b0;
            state_d  = ST_RUN;
            served_d = '0;
            t_d      = '0;
            wsum_d   = '0;
            tsum_d   = '0;
          end
        end
      end
      ST_RUN: begin
        valid_d                = 1'b1;
        result_d               = '0;
        result_d.status        = ptqs_pkg::STAT_SCHED;
        result_d.out_task_id   = entry_w[0].id;
        result_d.out_priority  = entry_w[0].prio;
        result_d.out_burst     = entry_w[0].burst;
        result_d.start_time    = t_q[14:0];
        result_d.finish_time   = finish[14:0];
        wsum_d                 = wsum_q + t_q;
        tsum_d                 = tsum_q + finish;
        t_d                    = finish;
        served_d               = served_q + CNT_W'(1);
        count_d                = count_q - CNT_W'(1);
        if (count_q == CNT_W'(1)) begin
          result_d.turnaround_sum = tsum_d[19:0];
          result_d.wait_sum       = wsum_d[19:0];
          result_d.task_count     = 6'(served_d);
          result_d.last           = 1'b1;
          state_d                 = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      served_q <= '0;
      t_q      <= '0;
      wsum_q   <= '0;
      tsum_q   <= '0;
      valid_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      served_q <= served_d;
      t_q      <= t_d;
      wsum_q   <= wsum_d;
      tsum_q   <= tsum_d;
      valid_q  <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  `PTQS_ASSERT(a_count_bound, (count_q <= CNT_W'(QUEUE_DEPTH)), "queue count beyond depth")
  `PTQS_ASSERT(a_run_nonempty, (busy_o |-> (count_q != '0)), "run with empty queue")
  `PTQS_ASSERT(a_run_emits, (busy_o |=> valid_o), "run cycle without result")
  `PTQS_ASSERT(a_insert_ack, (ins_xfer |=> ins_ack), "insert without status result")
  `PTQS_ASSERT(a_last_idle, ((valid_o && result_o.last) |-> !busy_o), "busy after last result")

endmodule

// ===== sv/ptqs_cell.sv =====
// one slot of the sorted task chain
module ptqs_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ptqs_pkg::cell_ctrl_t ctrl_i,
  input  ptqs_pkg::entry_t     new_entry_i,
  input  logic                 occupied_i,
  input  logic                 prev_keep_i,
  input  ptqs_pkg::entry_t     prev_entry_i,
  input  ptqs_pkg::entry_t     next_entry_i,
  output logic                 keep_o,
  output ptqs_pkg::entry_t     entry_o
);

  ptqs_pkg::entry_t entry_q, entry_d;

  assign keep_o  = occupied_i && (entry_q.prio >= new_entry_i.prio);
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.shift) begin
      entry_d = next_entry_i;
    end else if (ctrl_i.insert && !keep_o) begin
      entry_d = prev_keep_i ? new_entry_i : prev_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// self-checking testbench for the priority task queue scheduler
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QDEPTH     = 32;
  localparam int unsigned N_ITEMS    = 460;
  localparam int unsigned IDLE_LIMIT = 2000;

  typedef struct {
    ptqs_pkg::item_t   item;
    bit                fixed;
    ptqs_pkg::status_e fst;
    logic              flast;
  } dir_row_t;

  // directed rows: typed status where it is plain, predictor otherwise
  localparam int unsigned N_DIR = 19;
  dir_row_t dir_tbl [N_DIR] = '{
    '{'{ptqs_pkg::ACT_RUN,    8'h00, 4'h0, 10'h000}, 1'b1, ptqs_pkg::STAT_EMPTY,    1'b1},
    '{'{ptqs_pkg::ACT_INSERT, 8'h00, 4'h0, 10'h000}, 1'b1, ptqs_pkg::STAT_INSERTED, 1'b0},
    '{'{ptqs_pkg::ACT_INSERT, 8'hff, 4'hf, 10'h3ff}, 1'b1, ptqs_pkg::STAT_INSERTED, 1'b0},
    '{'{ptqs_pkg::ACT_INSERT, 8'h55, 4'hf, 10'h3ff}, 1'b1, ptqs_pkg::STAT_INSERTED, 1'b0},
    '{'{ptqs_pkg::ACT_INSERT, 8'haa, 4'hf, 10'h200}, 1'b1, ptqs_pkg::STAT_INSERTED, 1'b0},
    '{'{ptqs_pkg::ACT_INSERT, 8'h03, 4'h7, 10'h001}, 1'b0, ptqs_pkg::STAT_INSERTED, 1'b0},
    '{'{ptqs_pkg::ACT_INSERT, 8'h04, 4'h0, 10'h3ff}, 1'b0, ptqs_pkg::STAT_INSERTED, 1'b0},
    '{'{ptqs_pkg::ACT_INSERT, 8'h05, 4'h8, 10'h064}, 1'b0, ptqs_pkg::STAT_INSERTED, 1'b0},
    '{'{ptqs_pkg::ACT_RUN,    8'h00, 4'h0, 10'h000}, 1'b0, ptqs_pkg::STAT_SCHED,    1'b0},
    '{'{ptqs_pkg::ACT_RUN,    8'hff, 4'hf, 10'h3ff}, 1'b1, ptqs_pkg::STAT_EMPTY,    1'b1},
    '{'{ptqs_pkg::ACT_INSERT, 8'h09, 4'h5, 10'h00a}, 1'b0, ptqs_pkg::STAT_INSERTED, 1'b0},
    '{'{ptqs_pkg::ACT_RUN,    8'h00, 4'h0, 10'h000}, 1'b0, ptqs_pkg::STAT_SCHED,    1'b0},
    '{'{ptqs_pkg::ACT_INSERT, 8'h10, 4'h3, 10'h00f}, 1'b0, ptqs_pkg::STAT_INSERTED, 1'b0},
    '{'{ptqs_pkg::ACT_INSERT, 8'h11, 4'h3, 10'h0f0}, 1'b0, ptqs_pkg::STAT_INSERTED, 1'b0},
    '{'{ptqs_pkg::ACT_INSERT, 8'h12, 4'h3, 10'h005}, 1'b0, ptqs_pkg::STAT_INSERTED, 1'b0},
    '{'{ptqs_pkg::ACT_INSERT, 8'h14, 4'h4, 10'h3ff}, 1'b0, ptqs_pkg::STAT_INSERTED, 1'b0},
    '{'{ptqs_pkg::ACT_INSERT, 8'h13, 4'h3, 10'h100}, 1'b0, ptqs_pkg::STAT_INSERTED, 1'b0},
    '{'{ptqs_pkg::ACT_RUN,    8'h00, 4'h0, 10'h000}, 1'b0, ptqs_pkg::STAT_SCHED,    1'b0},
    '{'{ptqs_pkg::ACT_RUN,    8'h00, 4'h0, 10'h000}, 1'b1, ptqs_pkg::STAT_EMPTY,    1'b1}
  };

  logic              clk_i;
  logic              rst_ni;
  logic              start_i;
  logic              busy_o;
  ptqs_pkg::item_t   item_i;
  logic              valid_o;
  ptqs_pkg::result_t result_o;

  ptqs_pkg::entry_t  ready_q [$];
  ptqs_pkg::result_t sched_due_q [$];

  int unsigned fail_cnt;
  int unsigned n_sent;
  int unsigned n_inserts;
  int unsigned n_dropped;
  int unsigned n_runs;
  int unsigned n_empty;
  int unsigned n_checked;
  int unsigned idle_cnt;
  int unsigned burst_left;
  bit          gaps_on;

  priority_task_queue_scheduler #(
    .QUEUE_DEPTH(QDEPTH)
  ) u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .item_i  (item_i),
    .valid_o (valid_o),
    .result_o(result_o)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  function automatic ptqs_pkg::item_t mk_item(logic act, int unsigned id,
                                              int unsigned prio, int unsigned burst);
    ptqs_pkg::item_t it;
    it.action       = act;
    it.task_id      = 8'(id);
    it.priority_req = 4'(prio);
    it.burst        = 10'(burst);
    return it;
  endfunction

  // sorted insert or full drain of the ready queue, queuing the results owed
  function automatic void plan_schedule(ptqs_pkg::item_t it);
    ptqs_pkg::result_t r;
    ptqs_pkg::entry_t  e;
    int                pos;
    int unsigned       t;
    int unsigned       tsum;
    int unsigned       wsum;
    if (it.action == ptqs_pkg::ACT_INSERT) begin
      r = '0;
      n_inserts++;
      if (ready_q.size() >= QDEPTH) begin
        r.status = ptqs_pkg::STAT_FULL;
        n_dropped++;
      end else begin
        r.status = ptqs_pkg::STAT_INSERTED;
        pos = 0;
        while (pos < ready_q.size() && ready_q[pos].prio >= it.priority_req) pos++;
        e.id    = it.task_id;
        e.prio  = it.priority_req;
        e.burst = it.burst;
        ready_q.insert(pos, e);
      end
      sched_due_q.push_back(r);
    end else if (ready_q.size() == 0) begin
      r        = '0;
      r.status = ptqs_pkg::STAT_EMPTY;
      r.last   = 1'b1;
      n_runs++;
      n_empty++;
      sched_due_q.push_back(r);
    end else begin
      t    = 0;
      tsum = 0;
      wsum = 0;
      n_runs++;
      foreach (ready_q[k]) begin
        r              = '0;
        r.status       = ptqs_pkg::STAT_SCHED;
        r.out_task_id  = ready_q[k].id;
        r.out_priority = ready_q[k].prio;
        r.out_burst    = ready_q[k].burst;
        r.start_time   = 15'(t);
        wsum += t;
        t    += ready_q[k].burst;
        tsum += t;
        r.finish_time  = 15'(t);
        if (k == ready_q.size() - 1) begin
          r.turnaround_sum = 20'(tsum);
          r.wait_sum       = 20'(wsum);
          r.task_count     = 6'(ready_q.size());
          r.last           = 1'b1;
        end
        sched_due_q.push_back(r);
      end
      ready_q.delete();
    end
  endfunction

  task automatic cmp_field(string fname, logic [19:0] want, logic [19:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, fname, want, got);
      fail_cnt++;
    end
  endtask

  // one transfer, with bursts and random gaps ahead of it
  task automatic send(ptqs_pkg::item_t it, bit fixed, ptqs_pkg::result_t fixed_res);
    int unsigned gap;
    if (gaps_on && burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap        = $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk_i);
        start_i <= 1'b0;
        item_i  <= ptqs_pkg::item_t'(23'($urandom));
      end
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk_i);
    start_i <= 1'b1;
    item_i  <= it;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    plan_schedule(it);
    if (fixed) sched_due_q[sched_due_q.size() - 1] = fixed_res;
    n_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (sched_due_q.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && valid_o === 1'b1) begin
      if (sched_due_q.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual %p", $time, result_o);
        fail_cnt++;
      end else begin
        ptqs_pkg::result_t want;
        want = sched_due_q.pop_front();
        cmp_field("status",         20'(want.status),         20'(result_o.status));
        cmp_field("out_task_id",    20'(want.out_task_id),    20'(result_o.out_task_id));
        cmp_field("out_priority",   20'(want.out_priority),   20'(result_o.out_priority));
        cmp_field("out_burst",      20'(want.out_burst),      20'(result_o.out_burst));
        cmp_field("start_time",     20'(want.start_time),     20'(result_o.start_time));
        cmp_field("finish_time",    20'(want.finish_time),    20'(result_o.finish_time));
        cmp_field("turnaround_sum", want.turnaround_sum,      result_o.turnaround_sum);
        cmp_field("wait_sum",       want.wait_sum,            result_o.wait_sum);
        cmp_field("task_count",     20'(want.task_count),     20'(result_o.task_count));
        cmp_field("last",           20'(want.last),           20'(result_o.last));
        n_checked++;
      end
    end
  end

  // stall watchdog: cycles without an input transfer
  always @(posedge clk_i) begin
    if (start_i === 1'b1 && busy_o === 1'b0) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= IDLE_LIMIT) begin
      $display("%0t ns: no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  initial begin
    ptqs_pkg::result_t fres;
    int unsigned       k;
    int unsigned       pmode;
    int unsigned       bmode;
    int unsigned       batch;
    rst_ni     = 1'b0;
    start_i    = 1'b0;
    item_i     = '0;
    fail_cnt   = 0;
    n_sent     = 0;
    n_inserts  = 0;
    n_dropped  = 0;
    n_runs     = 0;
    n_empty    = 0;
    n_checked  = 0;
    idle_cnt   = 0;
    burst_left = 0;
    gaps_on    = 1'b1;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tbl[i]) begin
      fres        = '0;
      fres.status = dir_tbl[i].fst;
      fres.last   = dir_tbl[i].flast;
      send(dir_tbl[i].item, dir_tbl[i].fixed, fres);
    end
    wait_drained();

    batch = 0;
    fres  = '0;
    while (n_sent < N_ITEMS) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      if (batch != 0 && $urandom_range(0, 9) == 0) begin
        send(mk_item(1'($urandom_range(0, 1)), $urandom_range(0, 255),
                     $urandom_range(0, 15), $urandom_range(0, 1023)), 1'b0, fres);
      end else begin
        // the first batch overfills the queue
        if (batch == 0) k = QDEPTH + 2;
        else if ($urandom_range(0, 5) == 0) k = $urandom_range(QDEPTH - 4, QDEPTH + 4);
        else k = $urandom_range(1, 8);
        pmode = $urandom_range(0, 2);
        bmode = $urandom_range(0, 4);
        repeat (k) begin
          send(mk_item(ptqs_pkg::ACT_INSERT, $urandom_range(0, 255),
                       (pmode == 0) ? $urandom_range(0, 2) : $urandom_range(0, 15),
                       (bmode == 0) ? 1023 : $urandom_range(0, 1023)), 1'b0, fres);
        end
        send(mk_item(ptqs_pkg::ACT_RUN, $urandom_range(0, 255), $urandom_range(0, 15),
                     $urandom_range(0, 1023)), 1'b0, fres);
      end
      if ($urandom_range(0, 7) == 0) wait_drained();
      batch++;
    end

    @(negedge clk_i);
    start_i <= 1'b0;
    while (sched_due_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("covered %0d inserts (%0d dropped on a full queue), %0d runs (%0d on empty)",
             n_inserts, n_dropped, n_runs, n_empty);
    $display("%0d results checked, %0d field mismatches", n_checked, fail_cnt);
    if (fail_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== priority_task_queue_scheduler.f =====
+incdir+sv
sv/ptqs_pkg.sv
sv/ptqs_cell.sv
sv/priority_task_queue_scheduler.sv
tb/sv/tb_top.sv
